// ===== src/ile_pkg.sv =====
// Shared definitions for the indexed list engine: parameter defaults,
// request codes and status codes. No dependencies.

package ile_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int REQ_TYPE_BITS  = 3;
   localparam int POSITION_BITS  = 4;
   localparam int ITEM_BITS      = 32;
   localparam int LIST_SIZE_BITS = 5;
   localparam int STATUS_BITS    = 2;

   localparam logic [REQ_TYPE_BITS-1:0] OP_APPEND    = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] OP_INSERT    = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] OP_UPDATE    = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] OP_DEL_VALUE = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] OP_DEL_INDEX = 3'd4;
   localparam logic [REQ_TYPE_BITS-1:0] OP_CLEAR     = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] OP_READ      = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE   = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

endpackage

// ===== src/ile_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.

module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/indexed_list_engine.sv =====
// Indexed list engine top level: request sequencer, entry count and result
// register. Depends on ile_pkg and on ile_ram for the entry store.
//
//   Channel   | Ports                                          | Handshake
//   ----------+------------------------------------------------+---------------------------
//   request   | req_type, req_position, req_item_value         | start, taken when !busy
//   response  | rsp_read_value, rsp_list_size, rsp_status      | rsp_strobe, one cycle
//
// Every request beat produces exactly one response beat; for a request that raises
// busy, the beat appears in the same cycle that busy falls. Append, update, clear,
// the unused code, an insert at the end, a delete of the last entry and every
// request refused by the full, range or empty-list check answer in the cycle
// after acceptance without raising busy; a read raises busy while it waits in
// S_READ_WAIT for the RAM word. An insert below the end, a delete by index below
// the last entry and a delete by value on a non-empty list hold busy while they
// walk through the entry RAM with at most one read and one write per cycle. Reset
// is synchronous and empties the list; the RAM contents are not cleared. The
// receiver cannot stall: each response is shown for a single cycle.

module indexed_list_engine #(
   parameter int DEPTH     = ile_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = ile_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic        [ile_pkg::REQ_TYPE_BITS-1:0] req_type,
   input  logic        [ile_pkg::POSITION_BITS-1:0] req_position,
   input  logic signed [ile_pkg::ITEM_BITS-1:0]     req_item_value,
   output logic                                     rsp_strobe,
   output logic signed [ile_pkg::ITEM_BITS-1:0]     rsp_read_value,
   output logic        [ile_pkg::LIST_SIZE_BITS-1:0] rsp_list_size,
   output logic        [ile_pkg::STATUS_BITS-1:0]   rsp_status
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > ile_pkg::POSITION_BITS + 1) ? CW : ile_pkg::POSITION_BITS + 1;

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_READ_WAIT  = 6'b000010,
      S_SHIFT_UP   = 6'b000100,
      S_PUT        = 6'b001000,
      S_SHIFT_DOWN = 6'b010000,
      S_SEARCH     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [WORD_BITS-1:0] val_ff, val_in;

   logic                                 rsp_strobe_ff, rsp_fire;
   logic signed [ile_pkg::ITEM_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [ile_pkg::LIST_SIZE_BITS-1:0]   rsp_size_ff;
   logic [ile_pkg::STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   logic [CMP_W-1:0]     pos_ext, count_ext;
   logic [WORD_BITS-1:0] req_word;
   logic                 full;
   logic                 idx_has_next;

   // The item value is sign-extended or truncated to the stored word width.
   assign req_word     = WORD_BITS'(req_item_value);
   assign pos_ext      = CMP_W'(req_position);
   assign count_ext    = CMP_W'(count_ff);
   assign full         = (count_ff == CW'(DEPTH));
   assign idx_has_next = ((idx_ff + CW'(1)) < count_ff);

   ile_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer. The RAM read is registered, so the shift walks write the word
   // that arrived while already reading the next one.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(idx_ff);
      ram_wr_data   = val_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(idx_ff);
      rsp_fire      = 1'b0;
      rsp_status_in = ile_pkg::ST_OK;
      rsp_value_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in = CW'(req_position);
               val_in = req_word;
               unique case (req_type)
                  ile_pkg::OP_APPEND: begin
                     rsp_fire = 1'b1;
                     if (full) begin
                        rsp_status_in = ile_pkg::ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(count_ff);
                        ram_wr_data = req_word;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  ile_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_fire      = 1'b1;
                        rsp_status_in = ile_pkg::ST_FULL;
                     end else if (pos_ext > count_ext) begin
                        rsp_fire      = 1'b1;
                        rsp_status_in = ile_pkg::ST_RANGE;
                     end else if (pos_ext == count_ext) begin
                        // Inserting at the end is an append.
                        rsp_fire    = 1'b1;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(count_ff);
                        ram_wr_data = req_word;
                        count_in    = count_ff + CW'(1);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_ff - CW'(1));
                        idx_in      = count_ff - CW'(1);
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  ile_pkg::OP_UPDATE: begin
                     rsp_fire = 1'b1;
                     if (pos_ext >= count_ext) begin
                        rsp_status_in = ile_pkg::ST_RANGE;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(req_position);
                        ram_wr_data = req_word;
                     end
                  end
                  ile_pkg::OP_DEL_VALUE: begin
                     if (count_ff == '0) begin
                        rsp_fire      = 1'b1;
                        rsp_status_in = ile_pkg::ST_MISSING;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_SEARCH;
                     end
                  end
                  ile_pkg::OP_DEL_INDEX: begin
                     if (pos_ext >= count_ext) begin
                        rsp_fire      = 1'b1;
                        rsp_status_in = ile_pkg::ST_RANGE;
                     end else if ((pos_ext + CMP_W'(1)) < count_ext) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(pos_ext + CMP_W'(1));
                        idx_in      = CW'(pos_ext + CMP_W'(1));
                        state_in    = S_SHIFT_DOWN;
                     end else begin
                        // Last entry: nothing to close up.
                        rsp_fire = 1'b1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ile_pkg::OP_CLEAR: begin
                     rsp_fire = 1'b1;
                     count_in = '0;
                  end
                  ile_pkg::OP_READ: begin
                     if (pos_ext >= count_ext) begin
                        rsp_fire      = 1'b1;
                        rsp_status_in = ile_pkg::ST_RANGE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_position);
                        state_in    = S_READ_WAIT;
                     end
                  end
                  default: begin
                     rsp_fire = 1'b1;
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            rsp_fire     = 1'b1;
            rsp_value_in = ile_pkg::ITEM_BITS'($signed(ram_rd_data));
            state_in     = S_IDLE;
         end
         S_SHIFT_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(idx_ff + CW'(1));
            ram_wr_data = ram_rd_data;
            if (idx_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(idx_ff - CW'(1));
               idx_in      = idx_ff - CW'(1);
            end
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(pos_ff);
            ram_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
            rsp_fire    = 1'b1;
            state_in    = S_IDLE;
         end
         S_SHIFT_DOWN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(idx_ff - CW'(1));
            ram_wr_data = ram_rd_data;
            if (idx_has_next) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(idx_ff + CW'(1));
               idx_in      = idx_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               rsp_fire = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (ram_rd_data == val_ff) begin
               // First match found: close the gap it leaves.
               if (idx_has_next) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(idx_ff + CW'(1));
                  idx_in      = idx_ff + CW'(1);
                  state_in    = S_SHIFT_DOWN;
               end else begin
                  count_in = count_ff - CW'(1);
                  rsp_fire = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (idx_has_next) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(idx_ff + CW'(1));
               idx_in      = idx_ff + CW'(1);
            end else begin
               rsp_fire      = 1'b1;
               rsp_status_in = ile_pkg::ST_MISSING;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      if (rsp_fire) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_size_ff   <= ile_pkg::LIST_SIZE_BITS'(count_in);
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_list_size  = rsp_size_ff;
   assign rsp_status     = rsp_status_ff;

   // The list never holds more entries than the store has rows.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // A response beat only ever appears once the sequencer is back at rest.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("response beat while the sequencer is walking");

   // The entry count moves only together with a response beat.
   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_strobe_ff)
      else $error("entry count changed without a response");

   // A read answers and is back at rest in the cycle after S_READ_WAIT.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ_WAIT) |=> (rsp_strobe_ff && (state_ff == S_IDLE)))
      else $error("read did not answer after its RAM access");

   // The search and shift-down walks only ever touch live entries.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SEARCH) || (state_ff == S_SHIFT_DOWN)) |-> (idx_ff < count_ff))
      else $error("walk index beyond the live entries");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list engine: directed and random
// request beats against a mirror of the list. Depends on ile_pkg and the RTL.

module testbench;

   localparam int                                 DEPTH          = ile_pkg::DEPTH_DEFAULT;
   localparam int                                 WATCHDOG_LIMIT = 3000;
   localparam int                                 SETTLE_CYCLES  = 40;
   localparam int                                 RANDOM_BEATS   = 1150;
   localparam int                                 STEADY_BEATS   = 150;
   localparam logic [ile_pkg::REQ_TYPE_BITS-1:0]  OP_UNUSED      = 3'd7;

   typedef struct packed {
      logic signed [ile_pkg::ITEM_BITS-1:0]  read_value;
      logic [ile_pkg::LIST_SIZE_BITS-1:0]    list_size;
      logic [ile_pkg::STATUS_BITS-1:0]       status;
   } list_answer_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [ile_pkg::REQ_TYPE_BITS-1:0]     req_type;
   logic [ile_pkg::POSITION_BITS-1:0]     req_position;
   logic signed [ile_pkg::ITEM_BITS-1:0]  req_item_value;
   logic                                  rsp_strobe;
   logic signed [ile_pkg::ITEM_BITS-1:0]  rsp_read_value;
   logic [ile_pkg::LIST_SIZE_BITS-1:0]    rsp_list_size;
   logic [ile_pkg::STATUS_BITS-1:0]       rsp_status;

   // Mirror of the list contents and count, updated as each beat is accepted.
   logic signed [ile_pkg::ITEM_BITS-1:0]  list_mirror [DEPTH];
   int                                    list_count;

   // Answers worked out at acceptance, oldest first.
   list_answer_type                       awaited_answers [$];
   list_answer_type                       oldest_answer;

   int                                    mismatch_count;
   int                                    idle_cycles;
   int                                    burst_left;
   bit                                    bursty;
   bit                                    growing;

   indexed_list_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_list_size  (rsp_list_size),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the mirror and returns the answer the engine owes.
   // A failing request leaves the list and the count exactly as they were.
   function automatic list_answer_type step_list_mirror(
      logic [ile_pkg::REQ_TYPE_BITS-1:0] op,
      logic [ile_pkg::POSITION_BITS-1:0] pos,
      logic signed [ile_pkg::ITEM_BITS-1:0] val);
      list_answer_type ans;
      int              i;
      int              hit;
      ans.read_value = '0;
      ans.status     = ile_pkg::ST_OK;
      hit            = -1;
      case (op)
         ile_pkg::OP_APPEND: begin
            if (list_count >= DEPTH) ans.status = ile_pkg::ST_FULL;
            else begin
               list_mirror[list_count] = val;
               list_count++;
            end
         end
         ile_pkg::OP_INSERT: begin
            // The full check wins over the index check; pos equal to the
            // count is a legal insert that lands at the end.
            if (list_count >= DEPTH) ans.status = ile_pkg::ST_FULL;
            else if (pos > list_count) ans.status = ile_pkg::ST_RANGE;
            else begin
               for (i = list_count; i > pos; i--) list_mirror[i] = list_mirror[i-1];
               list_mirror[pos] = val;
               list_count++;
            end
         end
         ile_pkg::OP_UPDATE: begin
            if (pos >= list_count) ans.status = ile_pkg::ST_RANGE;
            else list_mirror[pos] = val;
         end
         ile_pkg::OP_DEL_VALUE: begin
            for (i = list_count - 1; i >= 0; i--)
               if (list_mirror[i] == val) hit = i;
            if (hit < 0) ans.status = ile_pkg::ST_MISSING;
            else begin
               for (i = hit; i + 1 < list_count; i++) list_mirror[i] = list_mirror[i+1];
               list_count--;
            end
         end
         ile_pkg::OP_DEL_INDEX: begin
            if (pos >= list_count) ans.status = ile_pkg::ST_RANGE;
            else begin
               for (i = pos; i + 1 < list_count; i++) list_mirror[i] = list_mirror[i+1];
               list_count--;
            end
         end
         ile_pkg::OP_CLEAR: list_count = 0;
         ile_pkg::OP_READ: begin
            if (pos >= list_count) ans.status = ile_pkg::ST_RANGE;
            else ans.read_value = list_mirror[pos];
         end
         default: ;
      endcase
      ans.list_size = list_count[ile_pkg::LIST_SIZE_BITS-1:0];
      return ans;
   endfunction

   // Biased toward the corners of the signed range and small values, otherwise
   // fully random so that every bit of the value field is seen in both states.
   function automatic logic signed [ile_pkg::ITEM_BITS-1:0] pick_word();
      case ($urandom_range(7, 0))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         4:       return $urandom_range(9, 0);
         default: return $urandom;
      endcase
   endfunction

   // Presents one request beat and holds it until the engine takes it. The
   // beat is accepted at the first rising edge that sees start high and busy
   // low; busy is read just after the edge, before any register updates land.
   // In bursty mode the sender drops start after a random number of beats and
   // sits out a random gap, so gaps fall across every phase of a long walk.
   task automatic send_beat(input logic [ile_pkg::REQ_TYPE_BITS-1:0] op,
                            input logic [ile_pkg::POSITION_BITS-1:0] pos,
                            input logic signed [ile_pkg::ITEM_BITS-1:0] val);
      req_type       <= op;
      req_position   <= pos;
      req_item_value <= val;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      awaited_answers.push_back(step_list_mirror(op, pos, val));
      if (bursty) begin
         burst_left--;
         if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(20, 1)) @(posedge clock);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
         end
      end
   endtask

   // Drops start and waits on the clock until every answer owed has
   // come back. Only ever called in a time step where start has not yet been
   // driven.
   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (awaited_answers.size() != 0);
   endtask

   // One random request, mostly well formed. The list drifts between empty
   // and full so that shifts of every length and the full case keep turning
   // up; delete-by-value mostly searches for a value that is really stored.
   task automatic send_random_beat();
      int                                    roll;
      logic [ile_pkg::REQ_TYPE_BITS-1:0]     op;
      logic [ile_pkg::POSITION_BITS-1:0]     pos;
      logic signed [ile_pkg::ITEM_BITS-1:0]  val;
      if (list_count == 0) growing = 1'b1;
      else if (list_count == DEPTH && $urandom_range(3, 0) == 0) growing = 1'b0;
      roll = $urandom_range(99, 0);
      if (growing) begin
         if (roll < 30) op = ile_pkg::OP_APPEND;
         else if (roll < 60) op = ile_pkg::OP_INSERT;
         else if (roll < 70) op = ile_pkg::OP_UPDATE;
         else if (roll < 78) op = ile_pkg::OP_DEL_VALUE;
         else if (roll < 86) op = ile_pkg::OP_DEL_INDEX;
         else if (roll < 98) op = ile_pkg::OP_READ;
         else if (roll < 99) op = ile_pkg::OP_CLEAR;
         else op = OP_UNUSED;
      end else begin
         if (roll < 8) op = ile_pkg::OP_APPEND;
         else if (roll < 16) op = ile_pkg::OP_INSERT;
         else if (roll < 26) op = ile_pkg::OP_UPDATE;
         else if (roll < 54) op = ile_pkg::OP_DEL_VALUE;
         else if (roll < 84) op = ile_pkg::OP_DEL_INDEX;
         else if (roll < 98) op = ile_pkg::OP_READ;
         else if (roll < 99) op = ile_pkg::OP_CLEAR;
         else op = OP_UNUSED;
      end
      if ($urandom_range(4, 0) == 0) pos = $urandom_range(15, 0);
      else if (op == ile_pkg::OP_INSERT)
         pos = $urandom_range(list_count < 15 ? list_count : 15, 0);
      else if (list_count > 0) pos = $urandom_range(list_count - 1, 0);
      else pos = $urandom_range(15, 0);
      if (op == ile_pkg::OP_DEL_VALUE && list_count > 0 && $urandom_range(3, 0) != 0)
         val = list_mirror[$urandom_range(list_count - 1, 0)];
      else
         val = pick_word();
      send_beat(op, pos, val);
   endtask

   // Read, update, both deletes and insert on an empty list, then the corners of
   // the value range, inserts at the front, middle and end, a found and a missing
   // search, the unused code and a clear.
   task automatic test_directed();
      send_beat(ile_pkg::OP_READ,      4'd0,  '0);
      send_beat(ile_pkg::OP_UPDATE,    4'd0,  32'sd1);
      send_beat(ile_pkg::OP_DEL_INDEX, 4'd0,  '0);
      send_beat(ile_pkg::OP_DEL_VALUE, 4'd0,  '0);
      send_beat(ile_pkg::OP_INSERT,    4'd1,  32'sd2);
      send_beat(ile_pkg::OP_INSERT,    4'd0,  32'sh8000_0000);
      send_beat(ile_pkg::OP_APPEND,    4'd15, 32'sh7fff_ffff);
      send_beat(ile_pkg::OP_APPEND,    4'd0,  -32'sd1);
      send_beat(ile_pkg::OP_APPEND,    4'd0,  '0);
      send_beat(ile_pkg::OP_INSERT,    4'd2,  32'sd5);
      send_beat(ile_pkg::OP_INSERT,    4'd5,  32'sh5a5a_a5a5);
      send_beat(ile_pkg::OP_INSERT,    4'd7,  32'sd9);
      send_beat(ile_pkg::OP_UPDATE,    4'd0,  32'sh1234_5678);
      send_beat(ile_pkg::OP_READ,      4'd0,  '0);
      send_beat(ile_pkg::OP_READ,      4'd2,  '0);
      send_beat(ile_pkg::OP_READ,      4'd5,  '0);
      send_beat(ile_pkg::OP_DEL_VALUE, 4'd0,  -32'sd1);
      send_beat(ile_pkg::OP_DEL_VALUE, 4'd0,  32'sd12345);
      send_beat(ile_pkg::OP_DEL_INDEX, 4'd0,  '0);
      send_beat(ile_pkg::OP_DEL_INDEX, 4'd3,  '0);
      send_beat(OP_UNUSED,             4'd15, -32'sd1);
      send_beat(ile_pkg::OP_READ,      4'd15, '0);
      send_beat(ile_pkg::OP_CLEAR,     4'd9,  32'sd3);
      send_beat(ile_pkg::OP_READ,      4'd0,  '0);
      send_beat(ile_pkg::OP_APPEND,    4'd0,  32'sh0f0f_0f0f);
   endtask

   // Fills the list to the brim, then asks for more: a full list must refuse
   // appends and inserts, the full check taking precedence over the index.
   task automatic test_full_list();
      send_beat(ile_pkg::OP_CLEAR, 4'd0, '0);
      for (int i = 0; i < DEPTH; i++) send_beat(ile_pkg::OP_APPEND, 4'd0, pick_word());
      send_beat(ile_pkg::OP_APPEND,    4'd0,  32'sd7);
      send_beat(ile_pkg::OP_INSERT,    4'd15, 32'sd7);
      send_beat(ile_pkg::OP_READ,      4'd15, '0);
      send_beat(ile_pkg::OP_UPDATE,    4'd15, 32'sh8000_0000);
      send_beat(ile_pkg::OP_DEL_INDEX, 4'd15, '0);
      send_beat(ile_pkg::OP_INSERT,    4'd15, 32'sd11);
      send_beat(ile_pkg::OP_DEL_INDEX, 4'd0,  '0);
      send_beat(ile_pkg::OP_INSERT,    4'd0,  32'sd13);
      send_beat(ile_pkg::OP_DEL_VALUE, 4'd0,  32'sd11);
   endtask

   // The bulk of the run. Halfway through the sender stops until every
   // answer is in, so the engine restarts from a fully quiet state.
   task automatic test_random_traffic();
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         send_random_beat();
         if (n == RANDOM_BEATS / 2) wait_all_answered();
      end
   endtask

   // Back-to-back beats with start never dropped, so each request is offered
   // straight after the edge at which the previous one is taken.
   task automatic test_back_to_back();
      bursty = 1'b0;
      for (int n = 0; n < STEADY_BEATS; n++) send_random_beat();
      bursty = 1'b1;
   endtask

   // Every response is compared field by field with the oldest answer owed.
   // Outputs are sampled at the edge that ends the strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_answers.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: response with none owed: read %0d size %0d status %0d",
                        $realtime, rsp_read_value, rsp_list_size, rsp_status);
            mismatch_count++;
         end else begin
            oldest_answer = awaited_answers.pop_front();
            if (rsp_read_value !== oldest_answer.read_value ||
                rsp_list_size !== oldest_answer.list_size ||
                rsp_status !== oldest_answer.status) begin
               if (mismatch_count < 10)
                  $display("%0t: expected read %0d size %0d status %0d, got %0d %0d %0d",
                           $realtime, oldest_answer.read_value, oldest_answer.list_size,
                           oldest_answer.status, rsp_read_value, rsp_list_size, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= ile_pkg::OP_APPEND;
      req_position   <= '0;
      req_item_value <= '0;
      list_count     = 0;
      mismatch_count = 0;
      idle_cycles    = 0;
      bursty         = 1'b1;
      growing        = 1'b1;
      burst_left     = $urandom_range(8, 1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_list();
      test_random_traffic();
      test_back_to_back();

      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_answers.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
